>>> sv/bgle_pkg.sv
package bgle_pkg;

	// Samples summed per block. The scaling below divides by a shift, so this
	// must stay a power of two between 1 and 16.
	localparam int SAMPLES_PER_BLOCK = 16;
	localparam int COUNT_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 16;
	localparam int GAIN_W   = 16;
	localparam int ALPHA_W  = 9;
	localparam int PCT_W    = 7;
	localparam int MV_W     = 16;
	localparam int SMOOTH_W = 24;
	localparam int FRAC_W   = 8;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	// Block average times Q4.12 gain: divide by samples and by 4096.
	localparam int SUM_SHIFT  = $clog2(SAMPLES_PER_BLOCK) + 12;
	localparam int GPROD_W    = SUM_W + GAIN_W;
	localparam int RAW_WIDE_W = GPROD_W + 1 - SUM_SHIFT;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_GAIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_ALPHA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WARN_PERCENT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_PERCENT = 2'd3;

	// Shared bit-serial multiplier.
	localparam int MCAND_W = 25;
	localparam int MPLR_W  = 16;
	localparam int PROD_W  = MCAND_W + MPLR_W;
	localparam int STEP_W  = $clog2(MPLR_W + 1);

	// Discharge curve, highest point first.
	localparam int CURVE_POINTS = 9;
	localparam int CURVE_IDX_W  = $clog2(CURVE_POINTS);
	localparam int SEGMENTS     = CURVE_POINTS - 1;
	localparam int SEG_W        = $clog2(SEGMENTS);
	localparam int CMV_W        = 14;
	localparam logic [CMV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
		14'd8400, 14'd8200, 14'd8000, 14'd7800, 14'd7600,
		14'd7400, 14'd7200, 14'd7000, 14'd6000
	};
	localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
		7'd100, 7'd90, 7'd75, 7'd60, 7'd45, 7'd30, 7'd15, 7'd5, 7'd0
	};
	localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
	localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

	// Interpolation widths: offset into a segment, percent drop, divider.
	localparam int X_W    = 10;
	localparam int DROP_W = 4;
	localparam int NUM_W  = 14;
	localparam int DEN_W  = X_W + 1;
	localparam int QUOT_W = DROP_W;
	localparam int DSTEP_W = $clog2(QUOT_W + 1);

	typedef struct packed {
		logic                      start;
		logic signed [MCAND_W-1:0] mcand;
		logic [MPLR_W-1:0]         mplier;
	} mul_req_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	function automatic logic [CMV_W-1:0] seg_lo_mv(input logic [SEG_W-1:0] seg);
		logic [CURVE_IDX_W-1:0] i;
		i = {1'b0, seg} + 1'b1;
		return CURVE_MV[i];
	endfunction

	function automatic logic [PCT_W-1:0] seg_lo_pct(input logic [SEG_W-1:0] seg);
		logic [CURVE_IDX_W-1:0] i;
		i = {1'b0, seg} + 1'b1;
		return CURVE_PCT[i];
	endfunction

	function automatic logic [X_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
		logic [CURVE_IDX_W-1:0] i;
		i = {1'b0, seg};
		return X_W'(CURVE_MV[i] - CURVE_MV[i + 1'b1]);
	endfunction

	function automatic logic [DROP_W-1:0] seg_drop(input logic [SEG_W-1:0] seg);
		logic [CURVE_IDX_W-1:0] i;
		i = {1'b0, seg};
		return DROP_W'(CURVE_PCT[i] - CURVE_PCT[i + 1'b1]);
	endfunction

endpackage

>>> sv/bgle_ifs.sv
interface bgle_sample_if;
	import bgle_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_mv;

	modport source(output valid, output sample_mv, input ready);
	modport sink(input valid, input sample_mv, output ready);
endinterface

interface bgle_result_if;
	import bgle_pkg::*;
	logic             valid;
	logic             ready;
	logic [MV_W-1:0]  battery_mv;
	logic [PCT_W-1:0] charge_percent;
	logic             low_warning;
	logic             lockout;

	modport source(output valid, output battery_mv, output charge_percent,
		output low_warning, output lockout, input ready);
	modport sink(input valid, input battery_mv, input charge_percent,
		input low_warning, input lockout, output ready);
endinterface

>>> sv/bgle_serial_mul.sv
module bgle_serial_mul import bgle_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mul_req_t                 req,
	output logic                     done,
	output logic signed [PROD_W-1:0] product
);

	logic signed [PROD_W-1:0]  acc_q;
	logic signed [MCAND_W-1:0] mcand_q;
	logic [MPLR_W-1:0]         mplr_q;
	logic [STEP_W-1:0]         cnt_q;
	logic                      done_q;

	logic signed [MCAND_W-1:0] addend;
	logic signed [MCAND_W-1:0] hi;
	logic signed [MCAND_W:0]   sum;

	// One multiplier bit per cycle: add into the upper half, then shift right.
	always_comb begin
		addend = mplr_q[0] ? mcand_q : '0;
		hi = acc_q[PROD_W-1:MPLR_W];
		sum = {hi[MCAND_W-1], hi} + {addend[MCAND_W-1], addend};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= STEP_W'(MPLR_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == STEP_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mcand_q <= req.mcand;
			mplr_q <= req.mplier;
		end else if (cnt_q != '0) begin
			acc_q <= {sum, acc_q[MPLR_W-1:1]};
			mplr_q <= mplr_q >> 1;
		end
	end

	assign done = done_q;
	assign product = acc_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (cnt_q == '0))
		else $error("multiplier started while busy");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == STEP_W'(1)) && !req.start |=> done_q)
		else $error("multiplier missed its done pulse");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == '0))
		else $error("multiplier done while still stepping");

endmodule

>>> sv/bgle_serial_div.sv
module bgle_serial_div import bgle_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	logic [NUM_W-1:0]   rem_q;
	logic [NUM_W-1:0]   dq_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [DSTEP_W-1:0] cnt_q;
	logic               done_q;
	logic               fits;

	assign fits = (rem_q >= dq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= DSTEP_W'(QUOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == DSTEP_W'(1));
			end
		end
	end

	// Restoring division, one quotient bit per cycle, most significant first.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dq_q <= NUM_W'({req.den, {(QUOT_W-1){1'b0}}});
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= rem_q - dq_q;
			end
			quot_q <= {quot_q[QUOT_W-2:0], fits};
			dq_q <= dq_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> sv/battery_gauge_lut_ema.sv
// Channel   | Dir | Payload                                            | Handshake
// sample_ch | in  | sample_mv[11:0]                                    | valid/ready
// result_ch | out | battery_mv[15:0] charge_percent[6:0] low_warning    | valid/ready
//           |     | lockout                                            |
// cfg       | in  | cfg_index[1:0] cfg_wdata[15:0]                     | cfg_we
//
// The fifteen samples before a block ends are taken even while a result waits
// in the output register. The sample that ends a block starts the work of the
// shared 16-step bit-serial multiplier, run three times (twice for the first
// block after reset), and a 4-step divider; no sample is taken until it ends.
// Reset is asynchronous; no item is lost when the result side stalls.
module battery_gauge_lut_ema import bgle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	bgle_sample_if.sink           sample_ch,
	bgle_result_if.source         result_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_GAIN   = 6'b000010,
		S_SMOOTH = 6'b000100,
		S_PSTART = 6'b001000,
		S_PMUL   = 6'b010000,
		S_DIV    = 6'b100000
	} state_t;

	state_t state_q;
	logic   emit_q;

	logic [GAIN_W-1:0]   gain_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [PCT_W-1:0]    warn_q;
	logic [PCT_W-1:0]    lock_q;

	logic [SUM_W-1:0]    sum_q;
	logic [COUNT_W-1:0]  count_q;
	logic [SMOOTH_W-1:0] smooth_q;
	logic                primed_q;

	logic [SEG_W-1:0]    seg_q;
	logic                sat_hi_q;
	logic                sat_lo_q;
	logic [PCT_W-1:0]    pct_q;

	logic                out_valid_q;
	logic [MV_W-1:0]     out_mv_q;
	logic [PCT_W-1:0]    out_pct_q;
	logic                out_warn_q;
	logic                out_lock_q;

	mul_req_t                 mul_req;
	logic                     mul_done;
	logic signed [PROD_W-1:0] mul_product;
	div_req_t                 div_req;
	logic                     div_done;
	logic [QUOT_W-1:0]        div_quot;

	logic                    sample_fire;
	logic                    block_end;
	logic [SUM_W-1:0]        sum_next;
	logic [GPROD_W:0]        gain_rnd;
	logic [RAW_WIDE_W-1:0]   raw_wide;
	logic [MV_W-1:0]         raw_mv;
	logic [ALPHA_W-1:0]      alpha_eff;
	logic signed [MCAND_W-1:0] smooth_diff;
	logic signed [PROD_W-1:0]  smooth_rnd;
	logic [MV_W-1:0]         mv;
	logic [SEG_W-1:0]        seg_c;
	logic [X_W-1:0]          x_c;
	logic                    out_free;

	assign sample_fire = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = (state_q == S_IDLE) && !emit_q;
	assign block_end = (count_q == COUNT_W'(SAMPLES_PER_BLOCK - 1));
	assign sum_next = sum_q + SUM_W'(sample_ch.sample_mv);
	assign out_free = !out_valid_q || result_ch.ready;

	// Rounded block scaling: (sum * gain + half) >> shift, saturated.
	always_comb begin
		gain_rnd = (GPROD_W + 1)'(mul_product[GPROD_W-1:0])
			+ (GPROD_W + 1)'(1 << (SUM_SHIFT - 1));
		raw_wide = gain_rnd[GPROD_W:SUM_SHIFT];
		raw_mv = (raw_wide > RAW_WIDE_W'({MV_W{1'b1}})) ? {MV_W{1'b1}} : raw_wide[MV_W-1:0];
		alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
		// s*(256-a) + r*a equals s*256 + (r-s)*a, so only one product is needed.
		smooth_diff = $signed({1'b0, raw_mv, {FRAC_W{1'b0}}}) - $signed({1'b0, smooth_q});
		smooth_rnd = mul_product + PROD_W'(signed'(128));
	end

	// Segment search over the curve: the first segment whose lower point is at
	// or below the voltage wins.
	always_comb begin
		mv = smooth_q[SMOOTH_W-1:FRAC_W];
		seg_c = SEG_W'(SEGMENTS - 1);
		for (int i = SEGMENTS - 1; i >= 0; i--) begin
			if (mv >= {2'b00, CURVE_MV[i+1]}) begin
				seg_c = SEG_W'(i);
			end
		end
		x_c = X_W'(mv - {2'b00, seg_lo_mv(seg_c)});
	end

	always_comb begin
		mul_req = '0;
		div_req = '0;
		case (state_q)
			S_IDLE: begin
				if (sample_fire && block_end) begin
					mul_req.start = 1'b1;
					mul_req.mcand = {{(MCAND_W-SUM_W){1'b0}}, sum_next};
					mul_req.mplier = gain_q;
				end
			end
			S_GAIN: begin
				if (mul_done && primed_q) begin
					mul_req.start = 1'b1;
					mul_req.mcand = smooth_diff;
					mul_req.mplier = {{(MPLR_W-ALPHA_W){1'b0}}, alpha_eff};
				end
			end
			S_PSTART: begin
				mul_req.start = 1'b1;
				mul_req.mcand = {{(MCAND_W-X_W){1'b0}}, x_c};
				mul_req.mplier = {{(MPLR_W-DROP_W){1'b0}}, seg_drop(seg_c)};
			end
			S_PMUL: begin
				if (mul_done) begin
					div_req.start = 1'b1;
					div_req.num = {mul_product[NUM_W-2:0], 1'b0} + NUM_W'(seg_span(seg_q));
					div_req.den = {seg_span(seg_q), 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 16'd16384;
			alpha_q <= 9'd51;
			warn_q <= 7'd25;
			lock_q <= 7'd15;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIVIDER_GAIN:    gain_q <= cfg_wdata[GAIN_W-1:0];
				CFG_SMOOTHING_ALPHA: alpha_q <= cfg_wdata[ALPHA_W-1:0];
				CFG_WARN_PERCENT:    warn_q <= cfg_wdata[PCT_W-1:0];
				CFG_LOCKOUT_PERCENT: lock_q <= cfg_wdata[PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			emit_q <= 1'b0;
			sum_q <= '0;
			count_q <= '0;
			smooth_q <= '0;
			primed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_q && out_free) begin
				out_valid_q <= 1'b1;
				emit_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sample_fire) begin
						sum_q <= block_end ? '0 : sum_next;
						count_q <= block_end ? '0 : count_q + 1'b1;
						if (block_end) begin
							state_q <= S_GAIN;
						end
					end
				end
				S_GAIN: begin
					if (mul_done) begin
						if (primed_q) begin
							state_q <= S_SMOOTH;
						end else begin
							smooth_q <= {raw_mv, {FRAC_W{1'b0}}};
							primed_q <= 1'b1;
							state_q <= S_PSTART;
						end
					end
				end
				S_SMOOTH: begin
					if (mul_done) begin
						smooth_q <= smooth_q + smooth_rnd[SMOOTH_W+FRAC_W-1:FRAC_W];
						state_q <= S_PSTART;
					end
				end
				S_PSTART: begin
					state_q <= S_PMUL;
				end
				S_PMUL: begin
					if (mul_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						emit_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PSTART) begin
			seg_q <= seg_c;
			sat_hi_q <= (mv >= {2'b00, CURVE_MV[0]});
			sat_lo_q <= (mv <= {2'b00, CURVE_MV[CURVE_POINTS-1]});
		end
		if (state_q == S_DIV && div_done) begin
			pct_q <= sat_hi_q ? PCT_FULL
				: sat_lo_q ? PCT_EMPTY
				: seg_lo_pct(seg_q) + PCT_W'(div_quot);
		end
		if (emit_q && out_free) begin
			out_mv_q <= smooth_q[SMOOTH_W-1:FRAC_W];
			out_pct_q <= pct_q;
			out_warn_q <= (pct_q <= warn_q);
			out_lock_q <= (pct_q <= lock_q);
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.battery_mv = out_mv_q;
	assign result_ch.charge_percent = out_pct_q;
	assign result_ch.low_warning = out_warn_q;
	assign result_ch.lockout = out_lock_q;

	bgle_serial_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req),
		.done(mul_done),
		.product(mul_product)
	);

	bgle_serial_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.done(div_done),
		.quot(div_quot)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(SAMPLES_PER_BLOCK - 1))
		else $error("sample count beyond block length");

	a_primed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q |=> primed_q)
		else $error("primed flag dropped after seeding");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_pct_q <= PCT_FULL))
		else $error("charge percent above full");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q && !out_valid_q |=> out_valid_q && !emit_q)
		else $error("pending result not moved to output register");

endmodule

>>> tb/sv/tb_battery_gauge_lut_ema.sv
`timescale 1ns / 1ps

module tb_battery_gauge_lut_ema;
	import bgle_pkg::*;

	localparam int unsigned MAX_SAMPLE    = (1 << SAMPLE_W) - 1;
	localparam int unsigned MAX_BLOCK_SUM = SAMPLES_PER_BLOCK * MAX_SAMPLE;
	localparam int unsigned GAIN_RESET    = 16384;
	localparam int unsigned SETTLE_CYCLES = 120;
	localparam int unsigned DRAIN_CYCLES  = 200;
	localparam int unsigned CYCLE_LIMIT   = 600000;

	localparam int unsigned KNEE_MV [9]  = '{8400, 8200, 8000, 7800, 7600, 7400, 7200, 7000, 6000};
	localparam int unsigned KNEE_PCT [9] = '{100, 90, 75, 60, 45, 30, 15, 5, 0};

	typedef struct packed {
		logic [MV_W-1:0]  battery_mv;
		logic [PCT_W-1:0] charge_percent;
		logic             low_warning;
		logic             lockout;
	} gauge_reading_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bgle_sample_if sample_ch();
	bgle_result_if result_ch();

	battery_gauge_lut_ema dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow of the gauge: registers and accumulation state.
	logic [GAIN_W-1:0]   gain_reg;
	logic [ALPHA_W-1:0]  alpha_reg;
	logic [PCT_W-1:0]    warn_reg;
	logic [PCT_W-1:0]    lock_reg;
	logic [SUM_W-1:0]    acc_sum;
	int unsigned         acc_count;
	logic [SMOOTH_W-1:0] ema_q8;
	logic                seeded;

	gauge_reading_t pending_readings[$];

	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;
	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned samples_sent;
	int unsigned readings_checked = 0;
	int unsigned settings_applied;
	int unsigned full_alpha_blocks;
	int unsigned pct_low_seen = 127;
	int unsigned pct_high_seen = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_battery_gauge_lut_ema failed");
			$finish;
		end
	end

	function automatic logic [PCT_W-1:0] percent_of_mv(input logic [MV_W-1:0] mv);
		int unsigned lo, span, drop, num;
		if (mv >= KNEE_MV[0])
			return PCT_W'(100);
		if (mv <= KNEE_MV[8])
			return PCT_W'(0);
		for (int k = 0; k < 8; k++) begin
			lo = KNEE_MV[k + 1];
			if (mv >= lo) begin
				span = KNEE_MV[k] - lo;
				drop = KNEE_PCT[k] - KNEE_PCT[k + 1];
				num  = (mv - lo) * drop;
				return PCT_W'(KNEE_PCT[k + 1] + (2 * num + span) / (2 * span));
			end
		end
		return PCT_W'(0);
	endfunction

	// Fold one accepted sample into the shadow state; a full block yields a reading.
	function automatic void absorb_sample(input logic [SAMPLE_W-1:0] s);
		logic [63:0] raw, weight, next;
		gauge_reading_t r;
		acc_sum = acc_sum + SUM_W'(s);
		if (acc_count + 1 < SAMPLES_PER_BLOCK) begin
			acc_count++;
			return;
		end
		raw = (64'(acc_sum) * gain_reg * 2 + 64'(SAMPLES_PER_BLOCK) * 4096)
			/ (64'(SAMPLES_PER_BLOCK) * 4096 * 2);
		if (raw > 65535)
			raw = 65535;
		acc_sum = '0;
		acc_count = 0;
		if (!seeded) begin
			ema_q8 = SMOOTH_W'(raw << FRAC_W);
			seeded = 1'b1;
		end else begin
			weight = (alpha_reg > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_reg);
			if (alpha_reg >= ALPHA_ONE)
				full_alpha_blocks++;
			next = (64'(ema_q8) * (256 - weight) + (raw << FRAC_W) * weight + 128) >> FRAC_W;
			ema_q8 = SMOOTH_W'(next);
		end
		r.battery_mv     = MV_W'(ema_q8 >> FRAC_W);
		r.charge_percent = percent_of_mv(r.battery_mv);
		r.low_warning    = (r.charge_percent <= warn_reg);
		r.lockout        = (r.charge_percent <= lock_reg);
		pending_readings.push_back(r);
	endfunction

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		gauge_reading_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected reading mv=%0d pct=%0d warn=%0b lock=%0b", $time,
					result_ch.battery_mv, result_ch.charge_percent,
					result_ch.low_warning, result_ch.lockout);
				mismatch_count++;
			end else begin
				want = pending_readings.pop_front();
				readings_checked++;
				if (result_ch.charge_percent < pct_low_seen)
					pct_low_seen = result_ch.charge_percent;
				if (result_ch.charge_percent > pct_high_seen)
					pct_high_seen = result_ch.charge_percent;
				if (result_ch.battery_mv !== want.battery_mv) begin
					$display("%0t: battery_mv expected %0d actual %0d", $time,
						want.battery_mv, result_ch.battery_mv);
					mismatch_count++;
				end
				if (result_ch.charge_percent !== want.charge_percent) begin
					$display("%0t: charge_percent expected %0d actual %0d", $time,
						want.charge_percent, result_ch.charge_percent);
					mismatch_count++;
				end
				if (result_ch.low_warning !== want.low_warning) begin
					$display("%0t: low_warning expected %0b actual %0b", $time,
						want.low_warning, result_ch.low_warning);
					mismatch_count++;
				end
				if (result_ch.lockout !== want.lockout) begin
					$display("%0t: lockout expected %0b actual %0b", $time,
						want.lockout, result_ch.lockout);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample_mv <= v;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		absorb_sample(v);
		samples_sent++;
	endtask

	// One block whose samples add up to the given total, spread at random.
	task automatic send_block_sum(input int unsigned total);
		int unsigned share [SAMPLES_PER_BLOCK];
		int unsigned i, j, room, amt;
		if (total > MAX_BLOCK_SUM)
			total = MAX_BLOCK_SUM;
		for (int k = 0; k < SAMPLES_PER_BLOCK; k++)
			share[k] = total / SAMPLES_PER_BLOCK + ((k < total % SAMPLES_PER_BLOCK) ? 1 : 0);
		repeat (2 * SAMPLES_PER_BLOCK) begin
			i = $urandom_range(SAMPLES_PER_BLOCK - 1);
			j = $urandom_range(SAMPLES_PER_BLOCK - 1);
			room = MAX_SAMPLE - share[j];
			if (share[i] < room)
				room = share[i];
			amt = $urandom_range(room);
			share[i] -= amt;
			share[j] += amt;
		end
		for (int k = 0; k < SAMPLES_PER_BLOCK; k++)
			send_sample(SAMPLE_W'(share[k]));
	endtask

	function automatic int unsigned sum_for_mv(input int unsigned mv);
		longint unsigned s;
		if (gain_reg == 0)
			return $urandom_range(MAX_BLOCK_SUM);
		s = (longint'(mv) * 65536 + gain_reg / 2) / gain_reg;
		return (s > MAX_BLOCK_SUM) ? MAX_BLOCK_SUM : int'(s);
	endfunction

	// Mostly voltages on the curve, with the knees, the clamps and beyond.
	function automatic int unsigned pick_mv();
		int unsigned k;
		k = $urandom_range(8);
		case ($urandom_range(9))
			0: return KNEE_MV[k];
			1: return KNEE_MV[k] + $urandom_range(3) - (($urandom_range(1) == 1) ? 4 : 0);
			2: return $urandom_range(5999);
			3: return $urandom_range(16380, 8400);
			default: return $urandom_range(8500, 5900);
		endcase
	endfunction

	task automatic send_block_at_mv();
		send_block_sum(sum_for_mv(pick_mv()));
	endtask

	task automatic realign_block();
		while (acc_count != 0)
			send_sample(SAMPLE_W'($urandom_range(MAX_SAMPLE)));
	endtask

	task automatic set_traffic(input int unsigned src, input int unsigned snk);
		src_idle_pct = src;
		snk_stall_pct = snk;
	endtask

	// Let the gauge finish any block in flight before touching registers.
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_DIVIDER_GAIN:    gain_reg = data;
			CFG_SMOOTHING_ALPHA: alpha_reg = data[ALPHA_W-1:0];
			CFG_WARN_PERCENT:    warn_reg = data[PCT_W-1:0];
			CFG_LOCKOUT_PERCENT: lock_reg = data[PCT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int unsigned gain, input int unsigned alpha,
		input int unsigned warn, input int unsigned lock);
		settle();
		write_reg(CFG_DIVIDER_GAIN, CFG_DATA_W'(gain));
		write_reg(CFG_SMOOTHING_ALPHA, CFG_DATA_W'(alpha));
		write_reg(CFG_WARN_PERCENT, CFG_DATA_W'(warn));
		write_reg(CFG_LOCKOUT_PERCENT, CFG_DATA_W'(lock));
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// Out of reset the first block loads the smoothed value directly.
	task automatic check_first_block_seeds();
		logic [SAMPLE_W-1:0] low_half [8];
		low_half = '{12'h000, 12'h800, 12'h001, 12'h555, 12'h0F0, 12'h333, 12'h7FF, 12'h100};
		set_traffic(0, 0);
		foreach (low_half[k]) begin
			send_sample(low_half[k]);
			send_sample(SAMPLE_W'(MAX_SAMPLE) - low_half[k]);
		end
	endtask

	// Full weight on each new block, so every reading lands exactly on its target.
	task automatic check_curve_map();
		apply_settings(GAIN_RESET, ALPHA_ONE, 100, 0);
		for (int k = 0; k < 9; k++) begin
			send_block_sum(sum_for_mv(KNEE_MV[k]));
			send_block_sum(sum_for_mv(KNEE_MV[k] + 1));
		end
		// Exact halves round up in the widest and the highest segments.
		send_block_sum(sum_for_mv(6100));
		send_block_sum(sum_for_mv(8210));
		repeat (4) send_block_at_mv();
	endtask

	task automatic check_smoothing_weights();
		int unsigned weights [6];
		weights = '{0, 1, 255, 300, 511, 51};
		set_traffic(68, 0);
		foreach (weights[k]) begin
			apply_settings(GAIN_RESET, weights[k], 25, 15);
			repeat (3) send_block_at_mv();
		end
	endtask

	task automatic check_divider_gain();
		int unsigned gains [4];
		gains = '{0, 65535, 4096, $urandom_range(20000, 12000)};
		set_traffic(0, 68);
		foreach (gains[k]) begin
			apply_settings(gains[k], $urandom_range(256), 25, 15);
			repeat (2) send_block_sum($urandom_range(MAX_BLOCK_SUM));
			repeat (2) send_block_at_mv();
		end
	endtask

	task automatic check_warning_levels();
		int unsigned warns [5];
		int unsigned locks [5];
		warns = '{0, 100, 127, 60, $urandom_range(127)};
		locks = '{0, 100, 127, 75, $urandom_range(127)};
		set_traffic(37, 37);
		foreach (warns[k]) begin
			apply_settings(GAIN_RESET, ALPHA_ONE, warns[k], locks[k]);
			repeat (4) send_block_at_mv();
		end
	endtask

	// Random settings, well-formed blocks mixed with stray samples.
	task automatic check_mixed_traffic();
		int unsigned gain;
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: set_traffic(0, 0);
				1: set_traffic(68, 0);
				2: set_traffic(0, 68);
				default: set_traffic(37, 37);
			endcase
			gain = ($urandom_range(9) < 7) ? $urandom_range(20000, 12000)
				: $urandom_range(65535);
			apply_settings(gain, $urandom_range(511), $urandom_range(127),
				$urandom_range(127));
			repeat ($urandom_range(4, 2)) send_block_at_mv();
			repeat ($urandom_range(20)) send_sample(SAMPLE_W'($urandom_range(MAX_SAMPLE)));
			send_block_at_mv();
			realign_block();
			send_block_sum($urandom_range(MAX_BLOCK_SUM));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DIVIDER_GAIN;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_mv = '0;
		gain_reg = GAIN_W'(GAIN_RESET);
		alpha_reg = ALPHA_W'(51);
		warn_reg = PCT_W'(25);
		lock_reg = PCT_W'(15);
		acc_sum = '0;
		acc_count = 0;
		ema_q8 = '0;
		seeded = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		samples_sent = 0;
		settings_applied = 0;
		full_alpha_blocks = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_first_block_seeds();
		check_curve_map();
		check_smoothing_weights();
		check_divider_gain();
		check_warning_levels();
		check_mixed_traffic();

		sample_ch.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d samples, checked %0d readings under %0d register settings.",
			samples_sent, readings_checked, settings_applied);
		$display("Charge percent ranged %0d..%0d; %0d blocks ran at full smoothing weight.",
			pct_low_seen, pct_high_seen, full_alpha_blocks);
		if (mismatch_count == 0) begin
			$display("tb_battery_gauge_lut_ema passed");
		end else begin
			$display("tb_battery_gauge_lut_ema failed");
		end
		$finish;
	end

endmodule
